// ===== rtl/mmpw_pkg.sv =====
package mmpw_pkg;

	localparam int NWIN     = 4;
	localparam int WIN_W    = 2;
	localparam int SAMPLE_W = 13;
	localparam int SUM_W    = 25;
	localparam int AVG_W    = 21;
	localparam int LREG_W   = 13;
	localparam int TS_W     = 32;
	localparam int PWR_W    = 16;
	localparam int REQ_W    = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [SAMPLE_W-1:0] POWER_CAP = 13'd4999;

	localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_EOF    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

	localparam logic [WIN_W-1:0] WIN_LAST = 2'd3;

	localparam logic [LREG_W-1:0] LEN_A_RST = 13'd5;
	localparam logic [LREG_W-1:0] LEN_B_RST = 13'd60;
	localparam logic [LREG_W-1:0] LEN_C_RST = 13'd300;
	localparam logic [LREG_W-1:0] LEN_D_RST = 13'd1200;

	// controller to datapath
	typedef struct packed {
		logic              rec_load;
		logic              eof;
		logic              rd;
		logic              upd;
		logic              wr;
		logic              div_start;
		logic              out_load;
		logic [WIN_W-1:0]  win;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_sample;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/mmpw_if.sv =====
interface mmpw_req_if;
	import mmpw_pkg::*;
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [TS_W-1:0]  timestamp;
	logic             power_valid;
	logic [PWR_W-1:0] power_watts;

	modport source (output valid, req_type, timestamp, power_valid, power_watts, input ready);
	modport sink (input valid, req_type, timestamp, power_valid, power_watts, output ready);
endinterface

interface mmpw_rsp_if;
	import mmpw_pkg::*;
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window_index;
	logic [SUM_W-1:0] best_sum;
	logic [AVG_W-1:0] best_avg_q8;
	logic             last_line;

	modport source (output valid, window_index, best_sum, best_avg_q8, last_line, input ready);
	modport sink (input valid, window_index, best_sum, best_avg_q8, last_line, output ready);
endinterface

// ===== rtl/mmpw_ctrl.sv =====
module mmpw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [mmpw_pkg::REQ_W-1:0]  in_req_type,
	output logic                        in_ready,
	input  mmpw_pkg::sts_t              sts,
	output mmpw_pkg::cmd_t              cmd
);
	import mmpw_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DWT  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [WIN_W-1:0] win_q, win_d;
	logic             acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	// sequence samples, end of file and report lines
	always_comb begin
		state_d       = state_q;
		win_d         = win_q;
		cmd           = '0;
		cmd.win       = win_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					win_d = '0;
					case (in_req_type)
						REQ_RECORD: begin
							cmd.rec_load = 1'b1;
							state_d      = ST_RD;
						end
						REQ_EOF:    cmd.eof = 1'b1;
						REQ_REPORT: state_d = ST_DIV;
						default:    ;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (win_q == WIN_LAST) begin
					state_d = ST_WR;
				end else begin
					win_d   = win_q + 1'b1;
					state_d = ST_RD;
				end
			end
			ST_WR: begin
				cmd.wr = 1'b1;
				win_d  = '0;
				state_d = sts.last_sample ? ST_IDLE : ST_RD;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWT;
			end
			ST_DWT: begin
				if (sts.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					if (win_q == WIN_LAST) begin
						state_d = ST_IDLE;
					end else begin
						win_d   = win_q + 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= '0;
		end else begin
			state_q <= state_d;
			win_q   <= win_d;
		end
	end

endmodule

// ===== rtl/mmpw_dp.sv =====
module mmpw_dp #(
	parameter int HISTORY_DEPTH = 4096,
	parameter int MAX_GAP       = 3600
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mmpw_pkg::TS_W-1:0]    in_timestamp,
	input  logic                         in_power_valid,
	input  logic [mmpw_pkg::PWR_W-1:0]   in_power_watts,
	input  mmpw_pkg::cmd_t               cmd,
	output mmpw_pkg::sts_t               sts,
	input  logic                         cfg_we,
	input  logic [mmpw_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [mmpw_pkg::DATA_W-1:0]  cfg_wdata,
	output logic [mmpw_pkg::DATA_W-1:0]  cfg_rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mmpw_pkg::WIN_W-1:0]   out_window_index,
	output logic [mmpw_pkg::SUM_W-1:0]   out_best_sum,
	output logic [mmpw_pkg::AVG_W-1:0]   out_best_avg_q8,
	output logic                         out_last_line
);
	import mmpw_pkg::*;

	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
	localparam int GAP_W = $clog2(MAX_GAP + 1);
	localparam int NUM_W = SUM_W + 8;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [LEN_W:0] DEPTH_X = (LEN_W+1)'(HISTORY_DEPTH);

	logic [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	logic [LREG_W-1:0] len_q  [NWIN];
	logic [LEN_W-1:0]  eff    [NWIN];
	logic [SUM_W-1:0]  sum_q  [NWIN];
	logic [SUM_W-1:0]  fmax_q [NWIN];
	logic [SUM_W-1:0]  best_q [NWIN];

	logic [PTR_W-1:0]    wp_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [TS_W-1:0]     prev_ts_q;
	logic                have_prev_q;
	logic [SAMPLE_W-1:0] pw_q;
	logic [GAP_W-1:0]    zeros_q;

	logic [SAMPLE_W-1:0] samp;
	logic [LEN_W-1:0]    d_cur;
	logic [LEN_W:0]      slot_x;
	logic [PTR_W-1:0]    slot;
	logic [SUM_W-1:0]    sum_new;
	logic                full_old, full_new;
	logic [TS_W-1:0]     diff;
	logic                gap_ok;
	logic [SAMPLE_W-1:0] clamp_v;

	logic [LEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] dcnt_q;
	logic             dbusy_q;
	logic [LEN_W:0]   rem_sh;
	logic             out_valid_q;

	// clamp window lengths to 1..HISTORY_DEPTH
	always_comb begin
		for (int i = 0; i < NWIN; i++) begin
			if (len_q[i] == '0)
				eff[i] = LEN_W'(1);
			else if (32'(len_q[i]) > HISTORY_DEPTH)
				eff[i] = LEN_W'(HISTORY_DEPTH);
			else
				eff[i] = LEN_W'(len_q[i]);
		end
	end

	assign cfg_rdata = DATA_W'(len_q[cfg_addr[3:2]]);

	// current sample: zero fill first, then the record's power
	assign sts.last_sample = (zeros_q == '0);
	assign samp            = sts.last_sample ? pw_q : '0;
	assign d_cur           = eff[cmd.win];

	// oldest sample leaving the window
	always_comb begin
		slot_x = {1'b0, LEN_W'(wp_q)} + DEPTH_X - {1'b0, d_cur};
		if (slot_x >= DEPTH_X) slot_x = slot_x - DEPTH_X;
		slot = slot_x[PTR_W-1:0];
	end

	assign full_old = (cnt_q >= d_cur);
	assign full_new = ({1'b0, cnt_q} + 1'b1 >= {1'b0, d_cur});
	assign sum_new  = sum_q[cmd.win] + SUM_W'(samp) - (full_old ? SUM_W'(rdata_q) : '0);

	assign diff    = in_timestamp - prev_ts_q;
	assign gap_ok  = (diff != '0) && !diff[TS_W-1] && (diff <= TS_W'(MAX_GAP));
	assign clamp_v = !in_power_valid ? '0 :
	                 (in_power_watts > PWR_W'(POWER_CAP)) ? POWER_CAP : SAMPLE_W'(in_power_watts);

	// history memory
	always_ff @(posedge clk) begin
		if (cmd.rd) rdata_q <= hist_mem[slot];
		if (cmd.wr) hist_mem[wp_q] <= samp;
	end

	// record latch
	always_ff @(posedge clk) begin
		if (cmd.rec_load) pw_q <= clamp_v;
	end

	// window state, file state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0]    <= LEN_A_RST;
			len_q[1]    <= LEN_B_RST;
			len_q[2]    <= LEN_C_RST;
			len_q[3]    <= LEN_D_RST;
			for (int i = 0; i < NWIN; i++) begin
				sum_q[i]  <= '0;
				fmax_q[i] <= '0;
				best_q[i] <= '0;
			end
			wp_q        <= '0;
			cnt_q       <= '0;
			prev_ts_q   <= '0;
			have_prev_q <= 1'b0;
			zeros_q     <= '0;
		end else begin
			if (cfg_we) begin
				len_q[cfg_addr[3:2]] <= cfg_wdata[LREG_W-1:0];
				cnt_q <= '0;
				for (int i = 0; i < NWIN; i++) begin
					sum_q[i]  <= '0;
					fmax_q[i] <= '0;
				end
			end
			if (cmd.rec_load) begin
				zeros_q     <= (have_prev_q && gap_ok) ? GAP_W'(diff - 1'b1) : '0;
				prev_ts_q   <= in_timestamp;
				have_prev_q <= 1'b1;
			end
			if (cmd.upd) begin
				sum_q[cmd.win] <= sum_new;
				if (full_new && sum_new > fmax_q[cmd.win]) fmax_q[cmd.win] <= sum_new;
			end
			if (cmd.wr) begin
				wp_q <= (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (cnt_q < LEN_W'(HISTORY_DEPTH)) cnt_q <= cnt_q + 1'b1;
				if (!sts.last_sample) zeros_q <= zeros_q - 1'b1;
			end
			if (cmd.eof) begin
				for (int i = 0; i < NWIN; i++) begin
					if (fmax_q[i] > best_q[i]) best_q[i] <= fmax_q[i];
					sum_q[i]  <= '0;
					fmax_q[i] <= '0;
				end
				cnt_q       <= '0;
				have_prev_q <= 1'b0;
			end
			if (cmd.out_load) best_q[cmd.win] <= '0;
		end
	end

	// restoring divider: best sum times 256 over window length, one bit a cycle
	assign rem_sh       = {rem_q[LEN_W-1:0], quo_q[NUM_W-1]};
	assign sts.div_done = !dbusy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
		end else if (cmd.div_start) begin
			dbusy_q <= 1'b1;
			dcnt_q  <= CNT_W'(NUM_W);
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (dcnt_q == CNT_W'(1)) dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= {best_q[cmd.win], 8'd0};
		end else if (dbusy_q) begin
			if (rem_sh >= {1'b0, d_cur}) begin
				rem_q <= rem_sh - {1'b0, d_cur};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// output register
	assign sts.out_busy = out_valid_q;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_window_index <= cmd.win;
			out_best_sum     <= best_q[cmd.win];
			out_best_avg_q8  <= quo_q[AVG_W-1:0];
			out_last_line    <= (cmd.win == WIN_LAST);
		end
	end

endmodule

// ===== rtl/mean_max_power_windows_unit.sv =====
// Mean-maximal power over four sliding windows. Each record item is turned into
// one-per-second samples (gap minus one zero samples, then the clamped power);
// each sample takes a history read and a sum update for each of the four
// windows on the single-port history memory, then one write. A record gives
// at most MAX_GAP samples. End of file is applied when it is accepted. A
// report gives four result items, one per window, each after a bit-serial
// divide for the Q8 average. A new item is taken only when the previous one is
// finished. Window length registers sit at byte addresses 0, 4, 8, 12; writing
// one restarts the open file's window sums.
module mean_max_power_windows_unit #(
	parameter int HISTORY_DEPTH = 4096,
	parameter int MAX_GAP       = 3600
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mmpw_req_if.sink                     req,
	mmpw_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mmpw_pkg::ADDR_W-1:0]  paddr,
	input  logic [mmpw_pkg::DATA_W-1:0]  pwdata,
	output logic [mmpw_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import mmpw_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	mmpw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	mmpw_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MAX_GAP       (MAX_GAP)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_timestamp     (req.timestamp),
		.in_power_valid   (req.power_valid),
		.in_power_watts   (req.power_watts),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_addr         (paddr),
		.cfg_wdata        (pwdata),
		.cfg_rdata        (prdata),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_window_index (rsp.window_index),
		.out_best_sum     (rsp.best_sum),
		.out_best_avg_q8  (rsp.best_avg_q8),
		.out_last_line    (rsp.last_line)
	);

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import mmpw_pkg::*;

	localparam int HIST_DEPTH = 4096;
	localparam int GAP_LIMIT  = 3600;
	localparam int CYCLE_LIMIT = 40000000;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [ADDR_W-1:0] REG_LEN_A = 4'd0;
	localparam logic [ADDR_W-1:0] REG_LEN_B = 4'd4;
	localparam logic [ADDR_W-1:0] REG_LEN_C = 4'd8;
	localparam logic [ADDR_W-1:0] REG_LEN_D = 4'd12;

	typedef struct packed {
		logic [WIN_W-1:0] win;
		logic [SUM_W-1:0] sum;
		logic [AVG_W-1:0] avg;
		logic             last;
	} line_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	mmpw_req_if req ();
	mmpw_rsp_if rsp ();

	mean_max_power_windows_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [SAMPLE_W-1:0] hist [HIST_DEPTH];
	int unsigned         wr_ptr;
	int unsigned         file_cnt;
	logic [63:0]         win_sum [NWIN];
	logic [63:0]         file_max [NWIN];
	logic [63:0]         best [NWIN];
	logic [TS_W-1:0]     prev_ts;
	bit                  have_prev;
	logic [LREG_W-1:0]   len_reg [NWIN];

	line_t expected_lines [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [TS_W-1:0] next_ts = '0;

	always #5 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned eff_len(int w);
		int unsigned d;
		d = len_reg[w];
		if (d == 0) d = 1;
		if (d > HIST_DEPTH) d = HIST_DEPTH;
		return d;
	endfunction

	function automatic void clear_file();
		file_cnt = 0;
		for (int w = 0; w < NWIN; w++) begin
			win_sum[w] = 0;
			file_max[w] = 0;
		end
	endfunction

	function automatic void push_sample(logic [SAMPLE_W-1:0] v);
		int unsigned d;
		for (int w = 0; w < NWIN; w++) begin
			d = eff_len(w);
			win_sum[w] += v;
			if (file_cnt >= d)
				win_sum[w] -= hist[(wr_ptr + HIST_DEPTH - d) % HIST_DEPTH];
			if (file_cnt + 1 >= d && win_sum[w] > file_max[w])
				file_max[w] = win_sum[w];
		end
		hist[wr_ptr] = v;
		wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
		if (file_cnt < HIST_DEPTH)
			file_cnt++;
	endfunction

	// advance the predictor by one accepted item
	function automatic void predict_item(logic [REQ_W-1:0] kind, logic [TS_W-1:0] ts,
			logic pv, logic [PWR_W-1:0] pw);
		logic [SAMPLE_W-1:0] v;
		logic [TS_W-1:0]     diff;
		int unsigned         gap;
		line_t               l;
		logic [63:0]         d;
		case (kind)
			REQ_RECORD: begin
				v = !pv ? '0 : (pw > POWER_CAP ? POWER_CAP : pw[SAMPLE_W-1:0]);
				if (have_prev) begin
					diff = ts - prev_ts;
					gap = (diff == 0 || diff[31] || diff > GAP_LIMIT) ? 1 : diff;
					for (int i = 1; i < gap; i++)
						push_sample('0);
				end
				push_sample(v);
				prev_ts = ts;
				have_prev = 1'b1;
			end
			REQ_EOF: begin
				for (int w = 0; w < NWIN; w++)
					if (file_max[w] > best[w]) best[w] = file_max[w];
				clear_file();
				have_prev = 1'b0;
			end
			REQ_REPORT: begin
				for (int w = 0; w < NWIN; w++) begin
					d = eff_len(w);
					l.win = WIN_W'(w);
					l.sum = best[w][SUM_W-1:0];
					l.avg = AVG_W'((best[w] << 8) / d);
					l.last = (w == NWIN - 1);
					expected_lines.push_back(l);
					best[w] = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// send one item, idling first at random
	task automatic send_item(logic [REQ_W-1:0] kind, logic [TS_W-1:0] ts,
			logic pv, logic [PWR_W-1:0] pw);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.timestamp <= ts;
		req.power_valid <= pv;
		req.power_watts <= pw;
		do @(posedge clk); while (!req.ready);
		predict_item(kind, ts, pv, pw);
	endtask

	task automatic send_record(int unsigned step, logic pv, logic [PWR_W-1:0] pw);
		next_ts = next_ts + step;
		send_item(REQ_RECORD, next_ts, pv, pw);
	endtask

	// hold until every expected line has come
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_len(logic [ADDR_W-1:0] addr, logic [LREG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		len_reg[addr[3:2]] = val;
		clear_file();
	endtask

	// report to flush the block, then reprogram all four windows
	task automatic set_lengths(logic [LREG_W-1:0] a, logic [LREG_W-1:0] b,
			logic [LREG_W-1:0] c, logic [LREG_W-1:0] d);
		send_item(REQ_REPORT, '0, 1'b0, '0);
		drain();
		write_len(REG_LEN_A, a);
		write_len(REG_LEN_B, b);
		write_len(REG_LEN_C, c);
		write_len(REG_LEN_D, d);
	endtask

	// check each result line against the oldest expectation
	always @(posedge clk) begin
		line_t e;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_lines.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected line: win %0d sum %0d avg %0d last %0d",
							rsp.window_index, rsp.best_sum, rsp.best_avg_q8, rsp.last_line);
				end else begin
					e = expected_lines.pop_front();
					if (rsp.window_index !== e.win || rsp.best_sum !== e.sum ||
							rsp.best_avg_q8 !== e.avg || rsp.last_line !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("line mismatch: exp win %0d sum %0d avg %0d last %0d,",
								e.win, e.sum, e.avg, e.last,
								" got win %0d sum %0d avg %0d last %0d",
								rsp.window_index, rsp.best_sum, rsp.best_avg_q8,
								rsp.last_line);
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic test_directed();
		next_ts = 32'd100;
		send_item(REQ_RECORD, next_ts, 1'b1, 16'hFFFF);
		send_record(1, 1'b1, 16'd4999);
		send_record(1, 1'b1, 16'd5000);
		send_record(1, 1'b0, 16'hFFFF);
		send_record(1, 1'b1, 16'd0);
		send_record(3, 1'b1, 16'd1234);
		send_record(0, 1'b1, 16'd2000);
		send_item(REQ_RECORD, next_ts - 5, 1'b1, 16'd3000);
		next_ts = next_ts - 5;
		send_record(32'h8000_0000, 1'b1, 16'd77);
		send_record(GAP_LIMIT, 1'b1, 16'd4000);
		send_record(GAP_LIMIT + 1, 1'b1, 16'd4500);
		send_item(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_item(REQ_REPORT, '0, 1'b0, '0);
		send_item(REQ_EOF, '0, 1'b0, '0);
		send_item(REQ_REPORT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_item(REQ_REPORT, '0, 1'b0, '0);
		next_ts = 32'hFFFF_FFFE;
		send_item(REQ_RECORD, next_ts, 1'b1, 16'd4999);
		send_record(1, 1'b1, 16'd4999);
		send_record(1, 1'b1, 16'd4999);
		send_item(REQ_EOF, '0, 1'b0, '0);
		send_item(REQ_REPORT, '0, 1'b0, '0);
		drain();
	endtask

	task automatic run_file(int n_rec, int long_gaps);
		next_ts = $urandom;
		send_item(REQ_RECORD, next_ts, 1'b1, $urandom_range(0, 65535));
		for (int i = 0; i < n_rec; i++)
			send_record((i < long_gaps) ? GAP_LIMIT : $urandom_range(1, 4), 1'b1,
				$urandom_range(4000, 65535));
		send_item(REQ_EOF, '0, 1'b0, '0);
		send_item(REQ_REPORT, '0, 1'b0, '0);
	endtask

	task automatic test_config();
		set_lengths(13'd1, 13'd1, 13'd1, 13'd1);
		run_file(6, 0);
		set_lengths(13'd4096, 13'd4096, 13'd4096, 13'd4096);
		run_file(3, 2);
		set_lengths(13'd0, 13'd8191, 13'd4097, 13'd2);
		run_file(3, 2);
		set_lengths($urandom_range(1, 16), $urandom_range(1, 64),
			$urandom_range(1, 300), $urandom_range(1, 4096));
		run_file(8, 1);
		set_lengths(13'd3, 13'd7, 13'd12, 13'd20);
		drain();
	endtask

	task automatic test_random(int n);
		int r;
		next_ts = $urandom;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 72)
				send_record(($urandom_range(99) < 2) ? $urandom_range(100, GAP_LIMIT + 50) :
					$urandom_range(1, 5), $urandom_range(99) < 85,
					($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 5000));
			else if (r < 76)
				send_record($urandom, $urandom_range(1), $urandom);
			else if (r < 86) begin
				send_item(REQ_EOF, $urandom, $urandom_range(1), $urandom);
				next_ts = $urandom;
			end else if (r < 98)
				send_item(REQ_REPORT, $urandom, $urandom_range(1), $urandom);
			else
				send_item(REQ_UNUSED, $urandom, $urandom_range(1), $urandom);
			// pause until every expected line has come
			if (i == n / 2) drain();
		end
		send_item(REQ_EOF, '0, 1'b0, '0);
		send_item(REQ_REPORT, '0, 1'b0, '0);
		drain();
	endtask

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_RECORD;
		req.timestamp = '0;
		req.power_valid = 1'b0;
		req.power_watts = '0;
		rsp.ready = 1'b0;
		wr_ptr = 0;
		clear_file();
		for (int w = 0; w < NWIN; w++) best[w] = 0;
		prev_ts = '0;
		have_prev = 1'b0;
		len_reg[0] = LEN_A_RST;
		len_reg[1] = LEN_B_RST;
		len_reg[2] = LEN_C_RST;
		len_reg[3] = LEN_D_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_stall_pct = 58;
		test_directed();
		test_config();
		test_random(40);
		send_idle_pct = 58;
		recv_stall_pct = 37;
		set_lengths($urandom_range(1, 8), $urandom_range(1, 40),
			$urandom_range(1, 200), $urandom_range(1, 1000));
		test_random(40);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_lengths(LEN_A_RST, LEN_B_RST, LEN_C_RST, LEN_D_RST);
		test_random(40);

		if (expected_lines.size() != 0) errors++;
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mmpw_pkg.sv
rtl/mmpw_if.sv
rtl/mmpw_ctrl.sv
rtl/mmpw_dp.sv
rtl/mean_max_power_windows_unit.sv
dv/tb_top.sv
